// ===== design/vmm_pkg.sv =====
// Shared types, constants and helper functions for the von Mises mixture
// membership block. No dependencies; used by the controller, datapath and top.
package vmm_pkg;

	localparam int MAX_COMPONENTS_DEF = 8;
	localparam int ANGLE_BITS = 16;

	localparam int COUNT_W = 4;
	localparam int INDEX_W = 3;
	localparam int KAPPA_W = 16;
	localparam int LOC_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int LOGN_W = 20;
	localparam int ANGLE_W = 16;
	localparam int ID_W = 3;
	localparam int RESP_W = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_COMPONENT_COUNT = 1'b0;

	localparam logic [16:0] COS_C2 = 17'd80852;
	localparam logic [16:0] COS_C4 = 17'd16625;
	localparam logic [16:0] COS_C6 = 17'd1367;
	localparam logic [16:0] COS_C8 = 17'd60;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// Horner coefficient selectors, applied in this order.
	localparam logic [4:0] HC_C6 = 5'd0;
	localparam logic [4:0] HC_C4 = 5'd1;
	localparam logic [4:0] HC_C2 = 5'd2;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_START,
		OP_FOLD,
		OP_MUL_ZZ,
		OP_SET_W,
		OP_MUL_WS,
		OP_HORNER,
		OP_SET_MAG,
		OP_MUL_KM,
		OP_SET_A,
		OP_MUL_DL,
		OP_SET_Y,
		OP_MUL_FL,
		OP_SET_V,
		OP_MUL_VT,
		OP_MUL_XM,
		OP_SET_T,
		OP_MUL_WE,
		OP_SET_NUM,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [4:0] arg;
	} dp_cmd_t;

	function automatic logic [16:0] horner_coef(input logic [4:0] sel);
		logic [16:0] c;
		case (sel)
			HC_C6: c = COS_C6;
			HC_C4: c = COS_C4;
			default: c = COS_C2;
		endcase
		return c;
	endfunction

	// Exact floor(x/n) for x below 2^30 is (x * m) >> s.
	function automatic logic [31:0] recip_mult(input logic [2:0] n);
		logic [31:0] m;
		case (n)
			3'd3: m = 32'd2863311531;
			3'd5: m = 32'd1717986919;
			3'd6: m = 32'd1431655766;
			3'd7: m = 32'd1227133514;
			default: m = 32'd1;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] recip_shift(input logic [2:0] n);
		logic [5:0] s;
		case (n) inside
			3'd2: s = 6'd1;
			3'd4: s = 6'd2;
			3'd3, 3'd5, 3'd6, 3'd7: s = 6'd33;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== design/von_mises_mixture_membership.sv =====
// Each classify word walks the active components through the cosine pass, then the
// exponential pass, then the division pass, all through the one shared 32x32
// multiplier and the bit-serial divider. A load word is written as it is accepted.
// One classify word is in work at a time; the next is accepted while the last
// result still waits. Reset clears control and sets component_count to 1; the
// component tables hold nothing until loaded.
module von_mises_mixture_membership #(
	parameter int MAX_COMPONENTS = vmm_pkg::MAX_COMPONENTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vmm_pkg::PADDR_W-1:0]         paddr,
	input  logic [vmm_pkg::PDATA_W-1:0]         pwdata,
	output logic [vmm_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [vmm_pkg::INDEX_W-1:0]         component_index,
	input  logic [vmm_pkg::KAPPA_W-1:0]         concentration,
	input  logic [vmm_pkg::LOC_W-1:0]           location,
	input  logic [vmm_pkg::WEIGHT_W-1:0]        mix_weight,
	input  logic signed [vmm_pkg::LOGN_W-1:0]   log_normalizer,
	input  logic [vmm_pkg::ANGLE_W-1:0]         angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [vmm_pkg::ID_W-1:0]            component_id,
	output logic [vmm_pkg::RESP_W-1:0]          responsibility,
	output logic                                last_component
);
	import vmm_pkg::*;

	localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

	logic [COUNT_W-1:0] component_count_q;
	dp_cmd_t cmd;
	logic [IDX_W-1:0] comp_sel;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COMPONENT_COUNT) ? PDATA_W'(component_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_count_q <= COUNT_W'(1);
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_COMPONENT_COUNT) begin
			component_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	vmm_ctrl #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.component_count(component_count_q),
		.in_valid(in_valid),
		.operation(operation),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.comp_sel(comp_sel)
	);

	vmm_dp #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.IDX_W(IDX_W)
	) u_dp (
		.clk(clk),
		.cmd(cmd),
		.comp_sel(comp_sel),
		.component_index(component_index),
		.concentration(concentration),
		.location(location),
		.mix_weight(mix_weight),
		.log_normalizer(log_normalizer),
		.angle(angle),
		.component_id(component_id),
		.responsibility(responsibility),
		.last_component(last_component)
	);

endmodule

// ===== design/vmm_ctrl.sv =====
// Sequencer for the von Mises mixture block: walks the components through the
// cosine, exponential and division passes and runs the result handshake. Uses vmm_pkg.
module vmm_ctrl #(
	parameter int MAX_COMPONENTS = vmm_pkg::MAX_COMPONENTS_DEF,
	parameter int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [vmm_pkg::COUNT_W-1:0] component_count,
	input  logic                        in_valid,
	input  logic                        operation,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vmm_pkg::dp_cmd_t            cmd,
	output logic [IDX_W-1:0]            comp_sel
);
	import vmm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_FOLD, S_MZZ, S_SETW, S_MWS, S_HORN, S_MAG, S_MKM, S_SETA,
		S_MDL, S_SETY, S_MFL, S_SETV, S_MVT, S_MXM, S_SETT, S_MWE, S_SETN,
		S_DIVI, S_DIVS, S_EMIT
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] last_q;
	logic [4:0] cnt_q;
	logic out_valid_q;
	logic [COUNT_W:0] count_ext;
	logic [COUNT_W:0] count_eff;
	logic out_free;
	logic j_last;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign comp_sel = j_q;
	assign out_free = !out_valid_q || out_ready;
	assign j_last = (j_q == last_q);

	always_comb begin
		count_ext = {1'b0, component_count};
		if (count_ext == '0) begin
			count_eff = (COUNT_W + 1)'(1);
		end else if (count_ext > (COUNT_W + 1)'(MAX_COMPONENTS)) begin
			count_eff = (COUNT_W + 1)'(MAX_COMPONENTS);
		end else begin
			count_eff = count_ext;
		end
	end

	always_comb begin
		cmd.op = OP_NOP;
		cmd.arg = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = operation ? OP_START : OP_LOAD;
				end
			end
			S_FOLD: cmd.op = OP_FOLD;
			S_MZZ: cmd.op = OP_MUL_ZZ;
			S_SETW: cmd.op = OP_SET_W;
			S_MWS: cmd.op = OP_MUL_WS;
			S_HORN: cmd.op = OP_HORNER;
			S_MAG: cmd.op = OP_SET_MAG;
			S_MKM: cmd.op = OP_MUL_KM;
			S_SETA: begin
				cmd.op = OP_SET_A;
				cmd.arg = {4'd0, j_q == '0};
			end
			S_MDL: cmd.op = OP_MUL_DL;
			S_SETY: cmd.op = OP_SET_Y;
			S_MFL: cmd.op = OP_MUL_FL;
			S_SETV: cmd.op = OP_SET_V;
			S_MVT: cmd.op = OP_MUL_VT;
			S_MXM: cmd.op = OP_MUL_XM;
			S_SETT: cmd.op = OP_SET_T;
			S_MWE: cmd.op = OP_MUL_WE;
			S_SETN: cmd.op = OP_SET_NUM;
			S_DIVI: cmd.op = OP_DIV_INIT;
			S_DIVS: cmd.op = OP_DIV_STEP;
			S_EMIT: begin
				if (out_free) begin
					cmd.op = OP_EMIT;
					cmd.arg = {4'd0, j_last};
				end
			end
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			last_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may be registered while the old one is taken by out_ready.
			out_valid_q <= (state_q == S_EMIT && out_free) || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && operation) begin
						j_q <= '0;
						last_q <= IDX_W'(count_eff - (COUNT_W + 1)'(1));
						state_q <= S_FOLD;
					end
				end
				S_FOLD: state_q <= S_MZZ;
				S_MZZ: state_q <= S_SETW;
				S_SETW: begin
					cnt_q <= '0;
					state_q <= S_MWS;
				end
				S_MWS: state_q <= (cnt_q == 5'd3) ? S_MAG : S_HORN;
				S_HORN: begin
					cnt_q <= cnt_q + 5'd1;
					state_q <= S_MWS;
				end
				S_MAG: state_q <= S_MKM;
				S_MKM: state_q <= S_SETA;
				S_SETA: begin
					if (j_last) begin
						j_q <= '0;
						state_q <= S_MDL;
					end else begin
						j_q <= j_q + IDX_W'(1);
						state_q <= S_FOLD;
					end
				end
				S_MDL: state_q <= S_SETY;
				S_SETY: state_q <= S_MFL;
				S_MFL: state_q <= S_SETV;
				S_SETV: begin
					cnt_q <= 5'd7;
					state_q <= S_MVT;
				end
				S_MVT: state_q <= S_MXM;
				S_MXM: state_q <= S_SETT;
				S_SETT: begin
					if (cnt_q == 5'd1) begin
						state_q <= S_MWE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
						state_q <= S_MVT;
					end
				end
				S_MWE: state_q <= S_SETN;
				S_SETN: begin
					if (j_last) begin
						j_q <= '0;
						state_q <= S_DIVI;
					end else begin
						j_q <= j_q + IDX_W'(1);
						state_q <= S_MDL;
					end
				end
				S_DIVI: begin
					cnt_q <= 5'd16;
					state_q <= S_DIVS;
				end
				S_DIVS: begin
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (j_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + IDX_W'(1);
							state_q <= S_DIVI;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The component walk never runs past the last active component.
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (j_q <= last_q))
		else $error("component index past last active component");

	// An accepted classify word starts the cosine pass at component zero.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation) |=> (state_q == S_FOLD && j_q == '0))
		else $error("classify word did not start at component zero");

	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> out_free)
		else $error("result register overwritten");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

// ===== design/vmm_dp.sv =====
// Datapath for the von Mises mixture block: component tables, one shared
// multiplier, exponential and bit-serial divider. Uses vmm_pkg; driven by vmm_ctrl.
module vmm_dp #(
	parameter int MAX_COMPONENTS = vmm_pkg::MAX_COMPONENTS_DEF,
	parameter int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
	input  logic                                clk,
	input  vmm_pkg::dp_cmd_t                    cmd,
	input  logic [IDX_W-1:0]                    comp_sel,
	input  logic [vmm_pkg::INDEX_W-1:0]         component_index,
	input  logic [vmm_pkg::KAPPA_W-1:0]         concentration,
	input  logic [vmm_pkg::LOC_W-1:0]           location,
	input  logic [vmm_pkg::WEIGHT_W-1:0]        mix_weight,
	input  logic signed [vmm_pkg::LOGN_W-1:0]   log_normalizer,
	input  logic [vmm_pkg::ANGLE_W-1:0]         angle,
	output logic [vmm_pkg::ID_W-1:0]            component_id,
	output logic [vmm_pkg::RESP_W-1:0]          responsibility,
	output logic                                last_component
);
	import vmm_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam int A_W = 22;
	localparam int NUM_W = 46;
	localparam int SUM_W = NUM_W + $clog2(MAX_COMPONENTS) + 1;
	localparam int REM_W = SUM_W + 17;

	logic [KAPPA_W-1:0] kappa_q [MAX_COMPONENTS];
	logic [LOC_W-1:0] mean_q [MAX_COMPONENTS];
	logic [WEIGHT_W-1:0] weight_q [MAX_COMPONENTS];
	logic signed [LOGN_W-1:0] lognorm_q [MAX_COMPONENTS];
	logic signed [A_W-1:0] a_q [MAX_COMPONENTS];
	logic [NUM_W-1:0] num_q [MAX_COMPONENTS];

	logic [ANGLE_W-1:0] angle_q;
	logic [14:0] h_q;
	logic neg_q;
	logic [16:0] w_q;
	logic [16:0] s_q;
	logic [16:0] mag_q;
	logic signed [A_W-1:0] best_q;
	logic [10:0] k_q;
	logic [15:0] f_q;
	logic [29:0] v_q;
	logic [30:0] t_q;
	logic [SUM_W-1:0] sum_q;
	logic [REM_W-1:0] rem_q;
	logic [16:0] rq_q;
	logic [63:0] prod_q;

	logic [AB-1:0] diff;
	logic [15:0] phase;
	logic [16:0] h1;
	logic [16:0] z;
	logic [16:0] rnd16;
	logic [20:0] kc;
	logic signed [A_W-1:0] a_new;
	logic [A_W-1:0] d;
	logic [27:0] y;
	logic [30:0] e;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [REM_W-1:0] div_cmp;

	assign diff = AB'(angle_q) - AB'(mean_q[comp_sel]);

	if (AB >= 16) begin : g_phase_wide
		assign phase = diff[AB-1 -: 16];
	end else begin : g_phase_narrow
		assign phase = {diff, {(16 - AB){1'b0}}};
	end

	assign h1 = phase[15] ? (17'h10000 - {1'b0, phase}) : {1'b0, phase};
	assign z = {h_q, 2'b00};
	assign rnd16 = 17'((prod_q + 64'd32768) >> 16);
	assign kc = 21'((prod_q + 64'd2048) >> 12);
	assign a_new = (neg_q ? -$signed({1'b0, kc}) : $signed({1'b0, kc}))
		- A_W'(lognorm_q[comp_sel]);
	assign d = A_W'(best_q - a_q[comp_sel]);
	assign y = 28'((prod_q + 64'd2048) >> 12);
	assign e = (k_q >= 11'd31) ? 31'd0 : (t_q >> k_q[4:0]);
	assign div_cmp = REM_W'(sum_q) << cmd.arg;

	// One shared multiplier; every product lands in prod_q.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_ZZ: begin
				mul_a = 32'(z);
				mul_b = 32'(z);
			end
			OP_MUL_WS: begin
				mul_a = 32'(w_q);
				mul_b = 32'(s_q);
			end
			OP_MUL_KM: begin
				mul_a = 32'(kappa_q[comp_sel]);
				mul_b = 32'(mag_q);
			end
			OP_MUL_DL: begin
				mul_a = 32'(d);
				mul_b = 32'(LOG2E_Q16);
			end
			OP_MUL_FL: begin
				mul_a = 32'(f_q);
				mul_b = 32'(LN2_Q30);
			end
			OP_MUL_VT: begin
				mul_a = 32'(v_q);
				mul_b = 32'(t_q);
			end
			OP_MUL_XM: begin
				mul_a = 32'(prod_q[59:30]);
				mul_b = recip_mult(cmd.arg[2:0]);
			end
			OP_MUL_WE: begin
				mul_a = 32'(weight_q[comp_sel]);
				mul_b = 32'(e);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				if (32'(component_index) < 32'(MAX_COMPONENTS)) begin
					kappa_q[IDX_W'(component_index)] <= concentration;
					mean_q[IDX_W'(component_index)] <= location;
					weight_q[IDX_W'(component_index)] <= mix_weight;
					lognorm_q[IDX_W'(component_index)] <= log_normalizer;
				end
			end
			OP_START: begin
				angle_q <= angle;
				sum_q <= '0;
			end
			OP_FOLD: begin
				if (h1 > 17'h4000) begin
					neg_q <= 1'b1;
					h_q <= 15'(17'h8000 - h1);
				end else begin
					neg_q <= 1'b0;
					h_q <= h1[14:0];
				end
			end
			OP_SET_W: begin
				w_q <= rnd16;
				s_q <= COS_C8;
			end
			OP_HORNER: s_q <= horner_coef(cmd.arg) - rnd16;
			OP_SET_MAG: mag_q <= rnd16[16] ? 17'd0 : (17'h10000 - rnd16);
			OP_SET_A: begin
				a_q[comp_sel] <= a_new;
				if (cmd.arg[0] || (a_new > best_q)) begin
					best_q <= a_new;
				end
			end
			OP_SET_Y: begin
				k_q <= y[26:16];
				f_q <= y[15:0];
			end
			OP_SET_V: begin
				v_q <= prod_q[45:16];
				t_q <= Q30_ONE;
			end
			OP_SET_T: t_q <= Q30_ONE - 31'(prod_q >> recip_shift(cmd.arg[2:0]));
			OP_SET_NUM: begin
				num_q[comp_sel] <= prod_q[NUM_W-1:0];
				sum_q <= sum_q + SUM_W'(prod_q[NUM_W-1:0]);
			end
			OP_DIV_INIT: begin
				rem_q <= REM_W'({num_q[comp_sel], 16'd0}) + REM_W'(sum_q >> 1);
				rq_q <= '0;
			end
			OP_DIV_STEP: begin
				// A zero total leaves the quotient at zero.
				if (sum_q != '0 && rem_q >= div_cmp) begin
					rem_q <= rem_q - div_cmp;
					rq_q[cmd.arg] <= 1'b1;
				end
			end
			OP_EMIT: begin
				component_id <= ID_W'(comp_sel);
				responsibility <= rq_q[16] ? 16'hFFFF : rq_q[15:0];
				last_component <= cmd.arg[0];
			end
			OP_MUL_ZZ, OP_MUL_WS, OP_MUL_KM, OP_MUL_DL, OP_MUL_FL, OP_MUL_VT,
			OP_MUL_XM, OP_MUL_WE: prod_q <= mul_a * mul_b;
			default: ;
		endcase
	end

endmodule
